### hdl/mono_page_framebuffer_draw_top_assert.svh
// Assertion macros used by the checker of the frame buffer drawing engine.
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_TOP_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MPFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/mpfd_pkg.sv
// ----------------------------------------------------------------------------
// mpfd_pkg
// Types, constants and the font table of the page frame buffer drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfd_pkg;

   localparam int DEF_SCREEN_WIDTH  = 128;
   localparam int DEF_SCREEN_HEIGHT = 64;
   localparam int GLYPH_FIRST       = 32;
   localparam int GLYPH_LAST        = 95;
   localparam int GLYPH_COLS        = 5;
   localparam int GLYPH_ROWS        = 8;
   localparam int BOX_COUNT         = 4;

   typedef enum logic [2:0] {
      MODE_CLEAR = 3'd0,
      MODE_PIXEL = 3'd1,
      MODE_GLYPH = 3'd2,
      MODE_HLINE = 3'd3,
      MODE_VLINE = 3'd4,
      MODE_RECT  = 3'd5,
      MODE_FILL  = 3'd6,
      MODE_READ  = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_CLEAR,
      KIND_BOX,
      KIND_GLYPH,
      KIND_READ
   } kind_type;

   // Column range [c_lo, c_end) by row range [r_lo, r_end), already clipped.
   typedef struct packed {
      logic [7:0] c_lo;
      logic [7:0] c_end;
      logic [7:0] r_lo;
      logic [7:0] r_end;
   } box_type;

   typedef struct packed {
      kind_type                    kind;
      logic                        value;
      box_type [BOX_COUNT-1:0]     boxes;
      logic [7:0]                  gx;
      logic [7:0]                  gy;
      logic [5:0]                  gidx;
      logic [7:0]                  rd_x;
      logic [2:0]                  rd_page;
      logic                        rd_ok;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_BOX_SETUP,
      ST_BOX_RD,
      ST_BOX_WR,
      ST_GLY,
      ST_GLY_WR,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   localparam logic [7:0] GLYPH_ROM [64][GLYPH_COLS] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00},
      '{8'h00, 8'h07, 8'h00, 8'h07, 8'h00}, '{8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14},
      '{8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12}, '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62},
      '{8'h36, 8'h49, 8'h55, 8'h22, 8'h50}, '{8'h00, 8'h05, 8'h03, 8'h00, 8'h00},
      '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00}, '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00},
      '{8'h14, 8'h08, 8'h3E, 8'h08, 8'h14}, '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
      '{8'h00, 8'h50, 8'h30, 8'h00, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
      '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
      '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
      '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
      '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
      '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
      '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h00, 8'h56, 8'h36, 8'h00, 8'h00},
      '{8'h08, 8'h14, 8'h22, 8'h41, 8'h00}, '{8'h14, 8'h14, 8'h14, 8'h14, 8'h14},
      '{8'h00, 8'h41, 8'h22, 8'h14, 8'h08}, '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06},
      '{8'h32, 8'h49, 8'h79, 8'h41, 8'h3E}, '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
      '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
      '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
      '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01}, '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
      '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}, '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
      '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01}, '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
      '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
      '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
      '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
      '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}, '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
      '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}, '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
      '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}, '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
      '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63}, '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07},
      '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}, '{8'h00, 8'h7F, 8'h41, 8'h41, 8'h00},
      '{8'h02, 8'h04, 8'h08, 8'h10, 8'h20}, '{8'h00, 8'h41, 8'h41, 8'h7F, 8'h00},
      '{8'h04, 8'h02, 8'h01, 8'h02, 8'h04}, '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40}
   };

   // End of a span that starts at lo and runs len pixels, cut at the screen edge.
   function automatic logic [7:0] clip_end(input logic [7:0] lo, input logic [7:0] len,
                                           input logic [7:0] lim);
      logic [8:0] sum;
      sum = {1'b0, lo} + {1'b0, len};
      return (sum > {1'b0, lim}) ? lim : sum[7:0];
   endfunction

endpackage

`default_nettype wire

### hdl/mono_page_framebuffer_draw_top.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_top
// Drawing engine for a page-organized monochrome frame store.
//
//   channel   ports              handshake
//   ------------------------------------------------------------------
//   request   req_mode..req_page push / full, taken when push & !full
//   response  rsp_read_data      pop / empty, taken when pop & !empty
//
// Commands run one at a time in the back end; a two-entry command queue and
// a two-entry result queue let both sides stall on their own.
// Byte work is read-modify-write: a read and a write state per touched byte,
// one setup state per box; a glyph visits its 40 cells plus one write step per
// lit on-screen pixel. A clear writes every byte (width * pages) in turn, a
// read passes an address state and a data state. After reset a clearing pass
// over all width * pages bytes (1024 by default) runs with req_full high.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_page_framebuffer_draw_top #(
   parameter int SCREEN_WIDTH  = mpfd_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mpfd_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic [7:0] req_extent_w,
   input  logic [7:0] req_extent_h,
   input  logic       req_color,
   input  logic [7:0] req_char_code,
   input  logic [2:0] req_page,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_read_data
);

   mpfd_pkg::cmd_type cmd;
   logic front_full, avail, take, init_busy;

   assign req_full = front_full || init_busy;

   mpfd_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !req_full),
      .mode      (req_mode),
      .x         (req_x),
      .y         (req_y),
      .extent_w  (req_extent_w),
      .extent_h  (req_extent_h),
      .color     (req_color),
      .char_code (req_char_code),
      .page      (req_page),
      .take      (take),
      .full      (front_full),
      .avail     (avail),
      .cmd       (cmd)
   );

   mpfd_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .avail         (avail),
      .cmd           (cmd),
      .take          (take),
      .init_busy     (init_busy),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_read_data (rsp_read_data)
   );

endmodule

`default_nettype wire

### hdl/mpfd_front.sv
// ----------------------------------------------------------------------------
// mpfd_front
// Takes drawing items, turns each into a command of clipped boxes, a glyph,
// a clear, a read or a no-op, and holds the commands in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfd_front #(
   parameter int SCREEN_WIDTH  = mpfd_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mpfd_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [2:0]        mode,
   input  logic [7:0]        x,
   input  logic [7:0]        y,
   input  logic [7:0]        extent_w,
   input  logic [7:0]        extent_h,
   input  logic              color,
   input  logic [7:0]        char_code,
   input  logic [2:0]        page,
   input  logic              take,
   output logic              full,
   output logic              avail,
   output mpfd_pkg::cmd_type cmd
);

   localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
   localparam logic [7:0] WLIM = 8'(SCREEN_WIDTH);
   localparam logic [7:0] HLIM = 8'(SCREEN_HEIGHT);
   localparam logic [4:0] PLIM = 5'(PAGE_COUNT);

   mpfd_pkg::cmd_type cls;
   logic [7:0] x_end1, y_end1, col_end_w, row_end_h, y_bot, x_rt;

   mpfd_pkg::cmd_type q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      x_end1    = mpfd_pkg::clip_end(x, 8'd1, WLIM);
      y_end1    = mpfd_pkg::clip_end(y, 8'd1, HLIM);
      col_end_w = mpfd_pkg::clip_end(x, extent_w, WLIM);
      row_end_h = mpfd_pkg::clip_end(y, extent_h, HLIM);
      // Bottom row and right column wrap modulo 256 for zero extents.
      y_bot     = y + extent_h - 8'd1;
      x_rt      = x + extent_w - 8'd1;

      cls         = '0;
      cls.kind    = mpfd_pkg::KIND_NOP;
      cls.value   = 1'b1;
      cls.gx      = x;
      cls.gy      = y;
      cls.gidx    = 6'(char_code - 8'(mpfd_pkg::GLYPH_FIRST));
      cls.rd_x    = x;
      cls.rd_page = page;
      cls.rd_ok   = (x < WLIM) && ({2'b00, page} < PLIM);

      unique case (mpfd_pkg::mode_type'(mode))
         mpfd_pkg::MODE_CLEAR: begin
            cls.kind = mpfd_pkg::KIND_CLEAR;
         end
         mpfd_pkg::MODE_PIXEL: begin
            cls.kind     = mpfd_pkg::KIND_BOX;
            cls.value    = color;
            cls.boxes[0] = '{x, x_end1, y, y_end1};
         end
         mpfd_pkg::MODE_GLYPH: begin
            if ((char_code >= 8'(mpfd_pkg::GLYPH_FIRST)) &&
                (char_code <= 8'(mpfd_pkg::GLYPH_LAST))) begin
               cls.kind = mpfd_pkg::KIND_GLYPH;
            end
         end
         mpfd_pkg::MODE_HLINE: begin
            cls.kind     = mpfd_pkg::KIND_BOX;
            cls.boxes[0] = '{x, col_end_w, y, y_end1};
         end
         mpfd_pkg::MODE_VLINE: begin
            cls.kind     = mpfd_pkg::KIND_BOX;
            cls.boxes[0] = '{x, x_end1, y, row_end_h};
         end
         mpfd_pkg::MODE_RECT: begin
            cls.kind     = mpfd_pkg::KIND_BOX;
            cls.boxes[0] = '{x, col_end_w, y, y_end1};
            cls.boxes[1] = '{x, col_end_w, y_bot, mpfd_pkg::clip_end(y_bot, 8'd1, HLIM)};
            cls.boxes[2] = '{x, x_end1, y, row_end_h};
            cls.boxes[3] = '{x_rt, mpfd_pkg::clip_end(x_rt, 8'd1, WLIM), y, row_end_h};
         end
         mpfd_pkg::MODE_FILL: begin
            cls.kind     = mpfd_pkg::KIND_BOX;
            cls.boxes[0] = '{x, col_end_w, y, row_end_h};
         end
         mpfd_pkg::MODE_READ: begin
            cls.kind = mpfd_pkg::KIND_READ;
         end
         default: begin
            cls.kind = mpfd_pkg::KIND_NOP;
         end
      endcase
   end

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = take ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (push && !take) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && take) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

   assign full  = (cnt_ff == 2'd2);
   assign avail = (cnt_ff != 2'd0);
   assign cmd   = q_ff[rp_ff];

endmodule

`default_nettype wire

### hdl/mpfd_back.sv
// ----------------------------------------------------------------------------
// mpfd_back
// Executes commands against the page frame store by read-modify-write of
// whole bytes, and queues one result item per command.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfd_back #(
   parameter int SCREEN_WIDTH  = mpfd_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mpfd_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              avail,
   input  mpfd_pkg::cmd_type cmd,
   output logic              take,
   output logic              init_busy,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [7:0]        rsp_read_data
);

   localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
   localparam int DEPTH      = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [7:0] WLIM = 8'(SCREEN_WIDTH);
   localparam logic [7:0] HLIM = 8'(SCREEN_HEIGHT);
   localparam logic [1:0] LAST_BOX = 2'(mpfd_pkg::BOX_COUNT - 1);
   localparam logic [2:0] LAST_GCOL = 3'(mpfd_pkg::GLYPH_COLS - 1);
   localparam logic [2:0] LAST_GROW = 3'(mpfd_pkg::GLYPH_ROWS - 1);

   logic [7:0] mem [DEPTH];

   mpfd_pkg::state_type state_ff, state_in;
   mpfd_pkg::cmd_type   cmd_ff;
   logic [1:0]          box_ff, box_in;
   logic [7:0]          col_ff, col_in;
   logic [4:0]          pg_ff, pg_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [2:0]          gi_ff, gi_in, gj_ff, gj_in;
   logic [7:0]          res_ff, res_in;
   logic [7:0]          rdata_ff;

   mpfd_pkg::box_type   cur_box;
   logic                box_ok;
   logic [7:0]          last_row;
   logic [2:0]          lb, hb;
   logic [7:0]          mask;
   logic [7:0]          gcol, grow, gbits;
   logic                ghit, glyph_sel;
   logic [4:0]          sel_pg;
   logic [7:0]          sel_col;
   logic [ADDR_W-1:0]   mem_addr, wr_addr;
   logic                wr_en;
   logic [7:0]          wr_data;
   logic                res_push;

   logic [7:0]          rq_ff [2];
   logic                rwp_ff, rwp_in, rrp_ff, rrp_in;
   logic [1:0]          rcnt_ff, rcnt_in;
   logic                res_pop;

   always_comb begin
      cur_box  = cmd_ff.boxes[box_ff];
      box_ok   = (cur_box.c_lo < cur_box.c_end) && (cur_box.r_lo < cur_box.r_end);
      last_row = cur_box.r_end - 8'd1;
      lb       = (pg_ff == cur_box.r_lo[7:3]) ? cur_box.r_lo[2:0] : 3'd0;
      hb       = (pg_ff == last_row[7:3]) ? last_row[2:0] : 3'd7;
      mask     = (8'hFF << lb) & (8'hFF >> (3'd7 - hb));

      gcol  = cmd_ff.gx + {5'd0, gi_ff};
      grow  = cmd_ff.gy + {5'd0, gj_ff};
      gbits = mpfd_pkg::GLYPH_ROM[cmd_ff.gidx][gi_ff];
      ghit  = gbits[gj_ff] && (gcol < WLIM) && (grow < HLIM);

      glyph_sel = (state_ff == mpfd_pkg::ST_GLY) || (state_ff == mpfd_pkg::ST_GLY_WR);
      sel_pg    = glyph_sel ? grow[7:3] : pg_ff;
      sel_col   = glyph_sel ? gcol : col_ff;
      mem_addr  = ADDR_W'(ADDR_W'(sel_pg) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(sel_col);
   end

   always_comb begin
      state_in = state_ff;
      box_in   = box_ff;
      col_in   = col_ff;
      pg_in    = pg_ff;
      clr_in   = clr_ff;
      gi_in    = gi_ff;
      gj_in    = gj_ff;
      res_in   = res_ff;
      take     = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = mem_addr;
      wr_data  = 8'd0;
      res_push = 1'b0;

      unique case (state_ff)
         mpfd_pkg::ST_INIT, mpfd_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == LAST_ADDR) begin
               clr_in   = '0;
               state_in = (state_ff == mpfd_pkg::ST_INIT) ? mpfd_pkg::ST_IDLE
                                                          : mpfd_pkg::ST_DONE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         mpfd_pkg::ST_IDLE: begin
            if (avail) begin
               take   = 1'b1;
               res_in = 8'd0;
               box_in = 2'd0;
               gi_in  = 3'd0;
               gj_in  = 3'd0;
               clr_in = '0;
               col_in = cmd.rd_x;
               pg_in  = {2'b00, cmd.rd_page};
               unique case (cmd.kind)
                  mpfd_pkg::KIND_CLEAR: state_in = mpfd_pkg::ST_CLEAR;
                  mpfd_pkg::KIND_BOX:   state_in = mpfd_pkg::ST_BOX_SETUP;
                  mpfd_pkg::KIND_GLYPH: state_in = mpfd_pkg::ST_GLY;
                  mpfd_pkg::KIND_READ:  state_in = mpfd_pkg::ST_RD_ADDR;
                  default:              state_in = mpfd_pkg::ST_DONE;
               endcase
            end
         end
         mpfd_pkg::ST_BOX_SETUP: begin
            if (box_ok) begin
               col_in   = cur_box.c_lo;
               pg_in    = cur_box.r_lo[7:3];
               state_in = mpfd_pkg::ST_BOX_RD;
            end else if (box_ff == LAST_BOX) begin
               state_in = mpfd_pkg::ST_DONE;
            end else begin
               box_in = box_ff + 2'd1;
            end
         end
         mpfd_pkg::ST_BOX_RD: begin
            state_in = mpfd_pkg::ST_BOX_WR;
         end
         mpfd_pkg::ST_BOX_WR: begin
            wr_en   = 1'b1;
            wr_data = cmd_ff.value ? (rdata_ff | mask) : (rdata_ff & ~mask);
            if ((col_ff + 8'd1) < cur_box.c_end) begin
               col_in   = col_ff + 8'd1;
               state_in = mpfd_pkg::ST_BOX_RD;
            end else if (pg_ff != last_row[7:3]) begin
               col_in   = cur_box.c_lo;
               pg_in    = pg_ff + 5'd1;
               state_in = mpfd_pkg::ST_BOX_RD;
            end else if (box_ff == LAST_BOX) begin
               state_in = mpfd_pkg::ST_DONE;
            end else begin
               box_in   = box_ff + 2'd1;
               state_in = mpfd_pkg::ST_BOX_SETUP;
            end
         end
         mpfd_pkg::ST_GLY, mpfd_pkg::ST_GLY_WR: begin
            if (state_ff == mpfd_pkg::ST_GLY_WR) begin
               wr_en   = 1'b1;
               wr_data = rdata_ff | (8'h01 << grow[2:0]);
            end
            if ((state_ff == mpfd_pkg::ST_GLY) && ghit) begin
               // Fetch the byte first; the set lands in the next cycle.
               state_in = mpfd_pkg::ST_GLY_WR;
            end else if (gj_ff == LAST_GROW) begin
               gj_in = 3'd0;
               if (gi_ff == LAST_GCOL) begin
                  state_in = mpfd_pkg::ST_DONE;
               end else begin
                  gi_in    = gi_ff + 3'd1;
                  state_in = mpfd_pkg::ST_GLY;
               end
            end else begin
               gj_in    = gj_ff + 3'd1;
               state_in = mpfd_pkg::ST_GLY;
            end
         end
         mpfd_pkg::ST_RD_ADDR: begin
            state_in = mpfd_pkg::ST_RD_DATA;
         end
         mpfd_pkg::ST_RD_DATA: begin
            res_in   = cmd_ff.rd_ok ? rdata_ff : 8'd0;
            state_in = mpfd_pkg::ST_DONE;
         end
         mpfd_pkg::ST_DONE: begin
            if (rcnt_ff != 2'd2) begin
               res_push = 1'b1;
               state_in = mpfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpfd_pkg::ST_INIT;
         clr_ff   <= '0;
         box_ff   <= 2'd0;
         col_ff   <= 8'd0;
         pg_ff    <= 5'd0;
         gi_ff    <= 3'd0;
         gj_ff    <= 3'd0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         box_ff   <= box_in;
         col_ff   <= col_in;
         pg_ff    <= pg_in;
         gi_ff    <= gi_in;
         gj_ff    <= gj_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (take) begin
         cmd_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[mem_addr];
   end

   // Result queue.
   assign res_pop = rsp_pop && (rcnt_ff != 2'd0);

   always_comb begin
      rwp_in  = res_push ? ~rwp_ff : rwp_ff;
      rrp_in  = res_pop ? ~rrp_ff : rrp_ff;
      rcnt_in = rcnt_ff;
      if (res_push && !res_pop) begin
         rcnt_in = rcnt_ff + 2'd1;
      end else if (!res_push && res_pop) begin
         rcnt_in = rcnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rwp_ff  <= 1'b0;
         rrp_ff  <= 1'b0;
         rcnt_ff <= 2'd0;
      end else begin
         rwp_ff  <= rwp_in;
         rrp_ff  <= rrp_in;
         rcnt_ff <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_ff[rwp_ff] <= res_ff;
      end
   end

   assign rsp_empty     = (rcnt_ff == 2'd0);
   assign rsp_read_data = rq_ff[rrp_ff];
   assign init_busy     = (state_ff == mpfd_pkg::ST_INIT);

endmodule

`default_nettype wire

### hdl/mpfd_checker.sv
// ----------------------------------------------------------------------------
// mpfd_checker
// Port-level checks of the drawing engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mono_page_framebuffer_draw_top_assert.svh"

module mpfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_read_data
);

   // The store is swept clean after reset, so no item may enter at once.
   `MPFD_ASSERT_IMPL(a_full_after_reset, clock, reset, $fell(reset), req_full, "accepting during clear pass")
   `MPFD_ASSERT_IMPL(a_empty_after_reset, clock, reset, $fell(reset), rsp_empty, "result present after reset")
   `MPFD_ASSERT_NEXT(a_rsp_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty, "result item dropped")
   `MPFD_ASSERT_NEXT(a_rsp_stable, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_read_data), "result item changed")

endmodule

bind mono_page_framebuffer_draw_top mpfd_checker u_mpfd_checker (.*);

`default_nettype wire

### tb/mono_page_framebuffer_draw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_checker
// Watches the command and read-back channels of the frame buffer drawing
// engine. It keeps its own copy of the frame store, applies every accepted
// command to it, and compares each returned byte with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_page_framebuffer_draw_checker #(
   parameter int SCREEN_WIDTH  = mpfd_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = mpfd_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic [7:0] req_extent_w,
   input  logic [7:0] req_extent_h,
   input  logic       req_color,
   input  logic [7:0] req_char_code,
   input  logic [2:0] req_page,
   input  logic       rsp_pop,
   input  logic       rsp_empty,
   input  logic [7:0] rsp_read_data,
   output int         fail_count,
   output int         pending_count,
   output int         read_count
);

   localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;

   logic [7:0] pixels [SCREEN_WIDTH * PAGES];
   logic [7:0] expected_bytes [$];

   function automatic void plot(input int col, input int row, input bit on);
      int idx;
      if (col < 0 || row < 0 || col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return;
      idx = col + (row / 8) * SCREEN_WIDTH;
      pixels[idx][row % 8] = on;
   endfunction

   function automatic void span_h(input int col, input int row, input int len);
      for (int i = 0; i < len && col + i < SCREEN_WIDTH; i++) plot(col + i, row, 1'b1);
   endfunction

   function automatic void span_v(input int col, input int row, input int len);
      for (int i = 0; i < len && row + i < SCREEN_HEIGHT; i++) plot(col, row + i, 1'b1);
   endfunction

   // Applies one command to the local frame store and returns the byte read back.
   function automatic logic [7:0] draw_command(input mpfd_pkg::mode_type mode,
                                               input int x, input int y,
                                               input int w, input int h,
                                               input bit color, input int code,
                                               input int page);
      logic [7:0] data;
      logic [7:0] col_bits;
      data = 8'h00;
      case (mode)
         mpfd_pkg::MODE_CLEAR: begin
            foreach (pixels[k]) pixels[k] = 8'h00;
         end
         mpfd_pkg::MODE_PIXEL: plot(x, y, color);
         mpfd_pkg::MODE_GLYPH: begin
            if (code >= mpfd_pkg::GLYPH_FIRST && code <= mpfd_pkg::GLYPH_LAST) begin
               for (int i = 0; i < mpfd_pkg::GLYPH_COLS; i++) begin
                  col_bits = mpfd_pkg::GLYPH_ROM[code - mpfd_pkg::GLYPH_FIRST][i];
                  for (int j = 0; j < mpfd_pkg::GLYPH_ROWS; j++)
                     if (col_bits[j]) plot((x + i) & 255, (y + j) & 255, 1'b1);
               end
            end
         end
         mpfd_pkg::MODE_HLINE: span_h(x, y, w);
         mpfd_pkg::MODE_VLINE: span_v(x, y, h);
         mpfd_pkg::MODE_RECT: begin
            // Zero extents wrap the far edge to coordinate minus one.
            span_h(x, y, w);
            span_h(x, (y + h - 1) & 255, w);
            span_v(x, y, h);
            span_v((x + w - 1) & 255, y, h);
         end
         mpfd_pkg::MODE_FILL: begin
            for (int i = 0; i < h && y + i < SCREEN_HEIGHT; i++) span_h(x, y + i, w);
         end
         default: begin
            if (x < SCREEN_WIDTH && page < PAGES) data = pixels[x + page * SCREEN_WIDTH];
         end
      endcase
      return data;
   endfunction

   initial begin
      foreach (pixels[k]) pixels[k] = 8'h00;
   end

   assign pending_count = expected_bytes.size();

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
         read_count <= 0;
      end else begin
         if (req_push && !req_full)
            expected_bytes.push_back(draw_command(mpfd_pkg::mode_type'(req_mode), req_x,
               req_y, req_extent_w, req_extent_h, req_color, req_char_code, req_page));
         if (rsp_pop && !rsp_empty) begin
            read_count <= read_count + 1;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected result, actual read_data %02h", $time,
                        rsp_read_data);
               fail_count <= fail_count + 1;
            end else begin
               if (expected_bytes[0] !== rsp_read_data) begin
                  $display("%0t: read_data mismatch, expected %02h actual %02h", $time,
                           expected_bytes[0], rsp_read_data);
                  fail_count <= fail_count + 1;
               end
               void'(expected_bytes.pop_front());
            end
         end
      end
   end

endmodule

`default_nettype wire

### tb/mono_page_framebuffer_draw_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_top_test
// Drives drawing commands into the frame buffer engine: a directed set of
// edge cases, then random scenes that are read back byte by byte. A checker
// beside the engine predicts every read and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_page_framebuffer_draw_top_test;

   localparam int WATCHDOG_LIMIT = 20000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [2:0] req_mode = mpfd_pkg::MODE_CLEAR;
   logic [7:0] req_x = '0;
   logic [7:0] req_y = '0;
   logic [7:0] req_extent_w = '0;
   logic [7:0] req_extent_h = '0;
   logic       req_color = 1'b0;
   logic [7:0] req_char_code = '0;
   logic [2:0] req_page = '0;
   logic       rsp_pop = 1'b0;
   logic       rsp_empty;
   logic [7:0] rsp_read_data;
   int         fail_count;
   int         pending_count;
   int         read_count;
   int         sent_count = 0;
   int         idle_cycles = 0;
   bit         hold_off = 1'b0;
   bit         long_stall_done = 1'b0;
   bit         stimulus_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mono_page_framebuffer_draw_top u_dut (.*);

   mono_page_framebuffer_draw_checker u_checker (.*);

   // Offers one command and waits until it is taken.
   task automatic send_command(input mpfd_pkg::mode_type mode, input logic [7:0] x,
                               input logic [7:0] y, input logic [7:0] w,
                               input logic [7:0] h, input logic color,
                               input logic [7:0] code, input logic [2:0] page);
      req_push      <= 1'b1;
      req_mode      <= mode;
      req_x         <= x;
      req_y         <= y;
      req_extent_w  <= w;
      req_extent_h  <= h;
      req_color     <= color;
      req_char_code <= code;
      req_page      <= page;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sent_count++;
   endtask

   task automatic pause_sender(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Mostly on-screen coordinates, with some anywhere in the byte range.
   function automatic logic [7:0] pick_coord(input int lim);
      return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, lim - 1));
   endfunction

   // Small extents keep the drawing time short; large ones show up now and then.
   function automatic logic [7:0] pick_extent();
      case ($urandom_range(0, 7))
         0: return 8'($urandom);
         1: return 8'd0;
         default: return 8'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic send_random_command();
      mpfd_pkg::mode_type mode;
      logic [7:0] code;
      mode = mpfd_pkg::mode_type'($urandom_range(1, 7));
      if ($urandom_range(0, 199) == 0) mode = mpfd_pkg::MODE_CLEAR;
      code = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(32, 95));
      send_command(mode, pick_coord(128), pick_coord(64), pick_extent(), pick_extent(),
                   1'($urandom), code, 3'($urandom));
      if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 6));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: every mode, extremes of the fields and the wrap cases.
      send_command(mpfd_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_PIXEL, 8'd255, 8'd255, 8'hFF, 8'hFF, 1'b1, 8'hFF, 3'd7);
      send_command(mpfd_pkg::MODE_READ, 8'd127, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd7);
      send_command(mpfd_pkg::MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_GLYPH, 8'd10, 8'd3, 8'd0, 8'd0, 1'b0, 8'd48, 3'd0);
      send_command(mpfd_pkg::MODE_READ, 8'd11, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_GLYPH, 8'd254, 8'd252, 8'd0, 8'd0, 1'b0, 8'd95, 3'd0);
      send_command(mpfd_pkg::MODE_READ, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_GLYPH, 8'd20, 8'd20, 8'd0, 8'd0, 1'b0, 8'd31, 3'd0);
      send_command(mpfd_pkg::MODE_GLYPH, 8'd20, 8'd20, 8'd0, 8'd0, 1'b0, 8'd96, 3'd0);
      send_command(mpfd_pkg::MODE_GLYPH, 8'd124, 8'd60, 8'd0, 8'd0, 1'b0, 8'd32, 3'd0);
      send_command(mpfd_pkg::MODE_HLINE, 8'd120, 8'd9, 8'd255, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_VLINE, 8'd5, 8'd60, 8'd0, 8'd255, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_HLINE, 8'd200, 8'd9, 8'd10, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_RECT, 8'd30, 8'd30, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_RECT, 8'd0, 8'd0, 8'd128, 8'd64, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_FILL, 8'd100, 8'd40, 8'd255, 8'd255, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_READ, 8'd100, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd5);
      send_command(mpfd_pkg::MODE_READ, 8'd128, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_READ, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 8'd0, 3'd7);
      send_command(mpfd_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0);
      send_command(mpfd_pkg::MODE_READ, 8'd127, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd7);

      // Drain completely once before the random part.
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      // Random scenes: a burst of drawing, then a sweep of reads of it.
      while (sent_count < 1450) begin
         repeat ($urandom_range(3, 25)) send_random_command();
         repeat ($urandom_range(4, 16))
            send_command(mpfd_pkg::MODE_READ, 8'($urandom_range(0, 127)), 8'($urandom),
                         8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                         3'($urandom));
         pause_sender($urandom_range(0, 20));
         if (sent_count > 700 && sent_count < 760) begin
            while (pending_count != 0) @(posedge clock);
         end
      end
      req_push <= 1'b0;
      stimulus_done <= 1'b1;
   end

   // Receiver: random stalls, clean stretches, and one long hold-off while the
   // sender keeps offering random items.
   initial begin
      int phase;
      phase = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         phase++;
         if (!long_stall_done && sent_count >= 300) begin
            long_stall_done = 1'b1;
            hold_off = 1'b1;
            rsp_pop <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end else if ((phase / 64) % 3 == 0) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      @(posedge stimulus_done);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d commands over all modes, clipping and wrap cases;", sent_count);
      $display("checked %0d read-back results, %0d mismatches.", read_count, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
